[design/chs_pkg.sv]
// shared constants, operation codes and control structs of the chained hash set
// no dependencies; imported by every module of the block
`default_nettype none

package chs_pkg;

    localparam int BUCKETS_DEF = 1021;
    localparam int ENTRIES_DEF = 4096;

    localparam int KEY_W  = 64;
    localparam int KIND_W = 2;

    // key bits folded into the remainder per cycle
    localparam int MOD_STEP_BITS = 8;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic mod_start;
        logic head_rd;
        logic ent_rd_head;
        logic link_rd;
        logic insert;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic head_valid;
        logic key_match;
        logic link_valid;
        logic full;
        logic sweep_last;
    } t_status;

endpackage

`default_nettype wire

[design/chs_ram.sv]
// generic single write port, single read port ram with registered read data
// uses chs_pkg for address width
`default_nettype none

module chs_ram
    import chs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [addr_bits(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]           i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [addr_bits(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/chs_mod.sv]
// remainder unit: key mod BUCKETS, MOD_STEP_BITS dividend bits per cycle
// uses chs_pkg
`default_nettype none

module chs_mod
    import chs_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [KEY_W-1:0]           i_dividend,
    output logic                            o_done,
    output logic [addr_bits(BUCKETS)-1:0]   o_rem
);

    localparam int BKT_W = addr_bits(BUCKETS);
    localparam int RW    = BKT_W + 1;
    localparam int STEPS = KEY_W / MOD_STEP_BITS;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [RW-1:0] DIVISOR  = RW'(BUCKETS);
    localparam logic [CW-1:0] LAST_CNT = CW'(STEPS - 1);

    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    n_rem;
    logic [KEY_W-1:0] r_shift;
    logic [CW-1:0]    r_cnt;
    logic             r_run;
    logic             r_done;

    // restoring steps: remainder stays below the divisor after each one
    always_comb begin
        n_rem = r_rem;
        for (int i = 0; i < MOD_STEP_BITS; i++) begin
            n_rem = {n_rem[RW-2:0], r_shift[KEY_W-1-i]};
            if (n_rem >= DIVISOR) begin
                n_rem = n_rem - DIVISOR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_run) begin
            r_shift <= r_shift << MOD_STEP_BITS;
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[BKT_W-1:0];

endmodule

`default_nettype wire

[design/chs_dp.sv]
// datapath: key register, remainder unit, bucket head and entry rams, entry count
// uses chs_pkg, chs_mod, chs_ram
`default_nettype none

module chs_dp
    import chs_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire t_cmd             i_cmd,
    output t_status               o_status
);

    localparam int BKT_W = addr_bits(BUCKETS);
    localparam int ENT_W = addr_bits(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int HD_W  = 1 + ENT_W;
    localparam int EN_W  = KEY_W + 1 + ENT_W;
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ENTRIES);
    localparam logic [BKT_W-1:0] LAST_BKT  = BKT_W'(BUCKETS - 1);

    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count;
    logic [BKT_W-1:0] r_sweep;

    logic             mod_done;
    logic [BKT_W-1:0] bucket;

    logic             head_wr;
    logic [BKT_W-1:0] head_waddr;
    logic [HD_W-1:0]  head_wdata;
    logic [HD_W-1:0]  head_rdata;
    logic             head_vld;
    logic [ENT_W-1:0] head_idx;

    logic             ent_rd;
    logic [ENT_W-1:0] ent_raddr;
    logic [EN_W-1:0]  ent_wdata;
    logic [EN_W-1:0]  ent_rdata;
    logic [KEY_W-1:0] ent_key;
    logic             ent_link_vld;
    logic [ENT_W-1:0] ent_link;

    chs_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (i_key),
        .o_done     (mod_done),
        .o_rem      (bucket)
    );

    // bucket heads: {valid, newest entry index}; read data holds until the next read
    assign head_wr    = i_cmd.clr_step | i_cmd.insert;
    assign head_waddr = i_cmd.clr_step ? r_sweep : bucket;
    assign head_wdata = i_cmd.clr_step ? '0 : {1'b1, r_count[ENT_W-1:0]};
    assign head_vld   = head_rdata[HD_W-1];
    assign head_idx   = head_rdata[ENT_W-1:0];

    chs_ram #(
        .WIDTH (HD_W),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .i_clk     (i_clk),
        .i_wr_en   (head_wr),
        .i_wr_addr (head_waddr),
        .i_wr_data (head_wdata),
        .i_rd_en   (i_cmd.head_rd),
        .i_rd_addr (bucket),
        .o_rd_data (head_rdata)
    );

    // entries: {key, link valid, link to next older entry}
    assign ent_rd       = i_cmd.ent_rd_head | i_cmd.link_rd;
    assign ent_raddr    = i_cmd.ent_rd_head ? head_idx : ent_link;
    assign ent_wdata    = {r_key, head_vld, head_idx};
    assign ent_key      = ent_rdata[EN_W-1 -: KEY_W];
    assign ent_link_vld = ent_rdata[ENT_W];
    assign ent_link     = ent_rdata[ENT_W-1:0];

    chs_ram #(
        .WIDTH (EN_W),
        .DEPTH (ENTRIES)
    ) u_ent_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.insert),
        .i_wr_addr (r_count[ENT_W-1:0]),
        .i_wr_data (ent_wdata),
        .i_rd_en   (ent_rd),
        .i_rd_addr (ent_raddr),
        .o_rd_data (ent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sweep <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_count <= '0;
                r_sweep <= '0;
            end else if (i_cmd.clr_step) begin
                r_sweep <= (r_sweep == LAST_BKT) ? '0 : r_sweep + 1'b1;
            end else if (i_cmd.insert) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_key <= i_key;
        end
    end

    assign o_status.mod_done   = mod_done;
    assign o_status.head_valid = head_vld;
    assign o_status.key_match  = (ent_key == r_key);
    assign o_status.link_valid = ent_link_vld;
    assign o_status.full       = (r_count == FULL_CNT);
    assign o_status.sweep_last = (r_sweep == LAST_BKT);

    a_no_insert_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> r_count < FULL_CNT)
        else $error("insert issued with the entry store full");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond store size");

endmodule

`default_nettype wire

[design/chs_ctrl.sv]
// controller: sequences clear sweep, remainder, head read and chain walk
// uses chs_pkg; drives chs_dp through t_cmd and reads t_status
`default_nettype none

module chs_ctrl
    import chs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire t_status           i_status,
    output t_cmd                   o_cmd,
    output logic                   o_busy,
    output logic                   o_valid,
    output logic                   o_present,
    output logic                   o_full_res
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MOD,
        S_HCHK,
        S_ECHK
    } t_state;

    t_state r_state;
    logic   r_reply;
    logic   r_ins;
    logic   r_valid;
    logic   r_present;
    logic   r_full;
    logic   accept;
    logic   absent;

    assign accept = i_start && (r_state == S_IDLE);

    // chain walk ends without a match
    always_comb begin
        absent = 1'b0;
        unique case (r_state)
            S_HCHK:  absent = !i_status.head_valid;
            S_ECHK:  absent = !i_status.key_match && !i_status.link_valid;
            default: absent = 1'b0;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.clr_start = accept && (i_kind == KIND_CLEAR);
                o_cmd.mod_start = accept && (i_kind == KIND_FIND || i_kind == KIND_INSERT);
            end
            S_CLR:  o_cmd.clr_step = 1'b1;
            S_MOD:  o_cmd.head_rd = i_status.mod_done;
            S_HCHK: o_cmd.ent_rd_head = i_status.head_valid;
            S_ECHK: o_cmd.link_rd = !i_status.key_match && i_status.link_valid;
            default: o_cmd = '0;
        endcase
        o_cmd.insert = absent && r_ins && !i_status.full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_reply   <= 1'b0;
            r_ins     <= 1'b0;
            r_valid   <= 1'b0;
            r_present <= 1'b0;
            r_full    <= 1'b0;
        end else begin
            r_valid   <= 1'b0;
            r_present <= 1'b0;
            r_full    <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ins <= (i_kind == KIND_INSERT);
                        unique case (i_kind)
                            KIND_CLEAR: begin
                                r_reply <= 1'b1;
                                r_state <= S_CLR;
                            end
                            KIND_FIND, KIND_INSERT: r_state <= S_MOD;
                            default: r_valid <= 1'b1;
                        endcase
                    end
                end
                S_CLR: begin
                    if (i_status.sweep_last) begin
                        r_state <= S_IDLE;
                        r_valid <= r_reply;
                        r_reply <= 1'b0;
                    end
                end
                S_MOD: begin
                    if (i_status.mod_done) begin
                        r_state <= S_HCHK;
                    end
                end
                S_HCHK, S_ECHK: begin
                    if (absent) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                        r_full  <= r_ins && i_status.full;
                    end else if (r_state == S_HCHK) begin
                        r_state <= S_ECHK;
                    end else if (i_status.key_match) begin
                        r_state   <= S_IDLE;
                        r_valid   <= 1'b1;
                        r_present <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_present  = r_present;
    assign o_full_res = r_full;

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_IDLE)
        else $error("result strobe while an operation is in flight");

    a_lookup_starts_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == KIND_FIND || i_kind == KIND_INSERT)) |=> r_state == S_MOD)
        else $error("find or insert did not start the remainder");

    a_full_not_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_full && r_present))
        else $error("result flags both present and full");

    a_insert_only_for_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.insert |-> r_ins && (r_state == S_HCHK || r_state == S_ECHK))
        else $error("store written outside an insert");

endmodule

`default_nettype wire

[design/chained_hash_set_core.sv]
// Set of 64-bit keys by separate chaining: bucket = key mod BUCKETS, each bucket a
// linked chain of entries, newest first. A request is taken when start is high and
// busy low; one result per request appears on o_present/o_full_res for exactly one
// cycle with o_valid, and cannot be held off. A find or insert first passes the key
// through the remainder unit (8 key bits a cycle), then does one head ram read and
// one entry ram read per link, each with registered read data. The next request
// can be taken in the result cycle. An insert of a new key appends it at the next
// free entry; with all ENTRIES in use it is dropped and flagged on o_full_res. A
// clear sweeps the head ram one bucket a cycle and answers when the sweep ends;
// after reset the same sweep runs with busy high before the first request.
// uses chs_pkg, chs_ctrl, chs_dp
`default_nettype none

module chained_hash_set_core
    import chs_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [KEY_W-1:0]  i_key,
    output logic                   o_valid,
    output logic                   o_present,
    output logic                   o_full_res
);

    t_cmd    cmd;
    t_status status;

    chs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_kind     (i_kind),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_present  (o_present),
        .o_full_res (o_full_res)
    );

    chs_dp #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (i_key),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

`default_nettype wire

[sim/tb_chained_hash_set_core.sv]
// self-checking testbench for chained_hash_set_core: directed and random requests
// predicts every result with its own copy of the hash set; needs chs_pkg and the core only
`timescale 1ns / 100ps

module tb_chained_hash_set_core
    import chs_pkg::*;
();

    localparam int NBUCKETS   = BUCKETS_DEF;
    localparam int NENTRIES   = ENTRIES_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int MAX_GAP    = 12;
    localparam int POOL_DEPTH = 64;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic present;
        logic full_res;
    } t_answer;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [KIND_W-1:0] i_kind;
    logic [KEY_W-1:0]  i_key;
    logic              o_valid;
    logic              o_present;
    logic              o_full_res;

    // predicted contents of the set
    logic [12:0]      head_idx  [NBUCKETS];
    bit               head_used [NBUCKETS];
    logic [KEY_W-1:0] slot_key  [NENTRIES];
    logic [12:0]      slot_next [NENTRIES];
    bit               slot_more [NENTRIES];
    int               used_slots;

    t_answer          pending_answers[$];
    logic [KEY_W-1:0] key_pool[$];
    int               err_count;
    int               quiet_cycles;
    int               idle_pct;

    chained_hash_set_core #(
        .BUCKETS(NBUCKETS),
        .ENTRIES(NENTRIES)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_kind    (i_kind),
        .i_key     (i_key),
        .o_valid   (o_valid),
        .o_present (o_present),
        .o_full_res(o_full_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit chain_holds(input logic [KEY_W-1:0] key, input int bucket);
        int  idx;
        int  steps;
        bit  have;
        have  = head_used[bucket];
        idx   = int'(head_idx[bucket]);
        steps = 0;
        while (have && steps < used_slots) begin
            if (idx >= NENTRIES) return 1'b0;
            if (slot_key[idx] == key) return 1'b1;
            have = slot_more[idx];
            idx  = int'(slot_next[idx]);
            steps++;
        end
        return 1'b0;
    endfunction

    task automatic apply_hash_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                                 output t_answer ans);
        int bucket;
        bucket       = int'(key % 64'(NBUCKETS));
        ans.present  = 1'b0;
        ans.full_res = 1'b0;
        case (kind)
            KIND_CLEAR: begin
                foreach (head_used[b]) head_used[b] = 1'b0;
                used_slots = 0;
            end
            KIND_FIND: begin
                ans.present = chain_holds(key, bucket);
            end
            KIND_INSERT: begin
                ans.present = chain_holds(key, bucket);
                if (!ans.present) begin
                    if (used_slots >= NENTRIES) begin
                        ans.full_res = 1'b1;
                    end else begin
                        slot_key[used_slots]  = key;
                        slot_next[used_slots] = head_idx[bucket];
                        slot_more[used_slots] = head_used[bucket];
                        head_idx[bucket]      = 13'(used_slots);
                        head_used[bucket]     = 1'b1;
                        used_slots++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // one request: optional idle gap, then hold start until it is taken
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
        int      gap;
        t_answer ans;
        gap = 0;
        while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_kind <= kind;
        i_key  <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_hash_op(kind, key, ans);
        pending_answers.push_back(ans);
        if (kind == KIND_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
        end
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // mostly keys already seen or sharing their bucket, so chains get walked
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (key_pool.size() == 0 || r < 30) return rand_key();
        idx = $urandom_range(0, key_pool.size() - 1);
        if (r < 75) return key_pool[idx];
        return key_pool[idx] + 64'(NBUCKETS) * 64'($urandom_range(1, 3));
    endfunction

    task automatic test_directed_ops();
        logic [KEY_W-1:0] base;
        base = 64'd77;
        send_request(KIND_FIND, 64'd0);
        send_request(KIND_INSERT, 64'd0);
        send_request(KIND_FIND, 64'd0);
        send_request(KIND_INSERT, 64'd0);
        send_request(KIND_INSERT, '1);
        send_request(KIND_FIND, '1);
        send_request(KIND_FIND, '1 - 64'd1);
        // several keys in one bucket, then hits at the newest, a middle and the oldest entry, and a miss
        for (int i = 0; i < 5; i++) send_request(KIND_INSERT, base + 64'(NBUCKETS * i));
        send_request(KIND_FIND, base);
        send_request(KIND_FIND, base + 64'(NBUCKETS * 2));
        send_request(KIND_FIND, base + 64'(NBUCKETS * 4));
        send_request(KIND_FIND, base + 64'(NBUCKETS * 7));
        send_request(KIND_INSERT, base + 64'(NBUCKETS * 3));
        send_request(KIND_UNUSED, '1);
        send_request(KIND_FIND, 64'h5555_5555_5555_5555);
        send_request(KIND_CLEAR, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(KIND_FIND, 64'd0);
        send_request(KIND_FIND, base);
        send_request(KIND_INSERT, base);
        send_request(KIND_FIND, base);
    endtask

    task automatic test_random_ops(input int count, input int pct);
        int               r;
        logic [KIND_W-1:0] kind;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 999);
            if (r < 8)        kind = KIND_CLEAR;
            else if (r < 30)  kind = KIND_UNUSED;
            else if (r < 500) kind = KIND_FIND;
            else              kind = KIND_INSERT;
            send_request(kind, (kind == KIND_CLEAR) ? rand_key() : pick_key());
        end
    endtask

    // result checker: each strobe is matched against the oldest prediction
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_answers.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result present=%b full_res=%b", o_present, o_full_res);
            end else begin
                want = pending_answers.pop_front();
                if (o_present !== want.present || o_full_res !== want.full_res) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected present=%b full_res=%b, got %b %b",
                                 want.present, want.full_res, o_present, o_full_res);
                end
            end
        end
    end

    // watchdog on cycles with neither a request taken nor a result
    always @(posedge i_clk) begin
        if ((i_rst_n && start && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("chained_hash_set_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = KIND_CLEAR;
        i_key        = '0;
        err_count    = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        used_slots   = 0;
        foreach (head_used[b]) head_used[b] = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_random_ops(400, 0);
        test_random_ops(400, 70);
        test_random_ops(400, 30);
        test_random_ops(300, 0);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (err_count == 0 && pending_answers.size() == 0) begin
            $display("chained_hash_set_core verification clean");
        end else begin
            $display("chained_hash_set_core verification failed");
        end
        $finish;
    end

endmodule
